// File: rtl/ahpt_pkg.sv
`timescale 1ns / 1ps
package ahpt_pkg;

  localparam int CoordWidth   = 32;
  localparam int FracBits     = 16;
  localparam int AngleStages  = 16;
  localparam int TableLen     = 24;
  localparam int AngleWidth   = 16;
  localparam int AccWidth     = 32;

  typedef enum logic [2:0] {
    REG_CENTER_X = 3'd0,
    REG_CENTER_Y = 3'd1,
    REG_CENTER_Z = 3'd2,
    REG_INNER    = 3'd3,
    REG_OUTER    = 3'd4
  } reg_idx_e;

  localparam logic [31:0] InnerReset = 32'd65536;
  localparam logic [31:0] OuterReset = 32'd131072;

  // arctangent of 2^-i in units of 2^-32 turn
  function automatic logic [AccWidth-1:0] turn_atan(input int unsigned i);
    logic [AccWidth-1:0] t;
    t = '0;
    case (i)
      0:  t = 32'h20000000;
      1:  t = 32'h12E4051D;
      2:  t = 32'h09FB385B;
      3:  t = 32'h051111D4;
      4:  t = 32'h028B0D43;
      5:  t = 32'h0145D7E1;
      6:  t = 32'h00A2F61E;
      7:  t = 32'h00517C55;
      8:  t = 32'h0028BE53;
      9:  t = 32'h00145F2E;
      10: t = 32'h000A2F98;
      11: t = 32'h000517CC;
      12: t = 32'h00028BE6;
      13: t = 32'h000145F3;
      14: t = 32'h0000A2F9;
      15: t = 32'h0000517C;
      16: t = 32'h000028BE;
      17: t = 32'h0000145F;
      18: t = 32'h00000A2F;
      19: t = 32'h00000517;
      20: t = 32'h0000028B;
      21: t = 32'h00000145;
      22: t = 32'h000000A2;
      23: t = 32'h00000051;
      default: t = '0;
    endcase
    return t;
  endfunction

endpackage

// File: rtl/ahpt_stream_if.sv
`timescale 1ns / 1ps
interface ahpt_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/ahpt_cfg_if.sv
`timescale 1ns / 1ps
interface ahpt_cfg_if #(
  parameter int DataWidth = 32
);
  logic                 valid;
  logic                 ready;
  logic [2:0]           index;
  logic [DataWidth-1:0] wdata;

  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface

// File: rtl/annulus_hit_and_polar_texcoord.sv
`timescale 1ns / 1ps
// Annulus hit test and polar texture coordinates.
// Channels: in_if carries point_x/y/z and local_u/v, out_if carries hit,
// angle_turns, radial_pos and width_zero, both valid/ready streams. cfg_if
// writes the ring registers: 0 center_x, 1 center_y, 2 center_z,
// 3 inner_radius, 4 outer_radius; other indexes are ignored.
// Configuration is always ready and should only change while no item is
// in flight.
// Throughput is one item per cycle while the receiver does not stall. The
// result passes through the difference, square and sum stages,
// COORD_WIDTH+1 square-root stages, then COORD_WIDTH+3+FRAC_BITS divider
// stages, and the output register. The angle and hit path runs alongside in
// matched delay lines.
// The whole pipeline advances when the output register is empty or being
// taken; a receiver stall freezes every stage, so nothing is lost or
// repeated. Reset empties the pipeline and loads centre 0, inner 1.0,
// outer 2.0.
module annulus_hit_and_polar_texcoord #(
  parameter int COORD_WIDTH  = ahpt_pkg::CoordWidth,
  parameter int FRAC_BITS    = ahpt_pkg::FracBits,
  parameter int ANGLE_STAGES = ahpt_pkg::AngleStages
) (
  input  logic clk_i,
  input  logic rst_ni,
  ahpt_stream_if.sink   in_if,
  ahpt_stream_if.source out_if,
  ahpt_cfg_if.sink      cfg_if
);
  localparam int CW  = COORD_WIDTH;
  localparam int SQW = 2 * CW + 2;           // u^2+v^2, even width
  localparam int RW  = SQW / 2;              // root width
  localparam int DLW = 2 * CW + 3;           // distance squared sum
  localparam int NW  = RW + 2;               // numerator width, signed

  logic signed [CW-1:0] cx_q, cy_q, cz_q;
  logic [CW-2:0]        inner_q, outer_q;

  assign cfg_if.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q    <= '0;
      cy_q    <= '0;
      cz_q    <= '0;
      inner_q <= (CW-1)'(ahpt_pkg::InnerReset);
      outer_q <= (CW-1)'(ahpt_pkg::OuterReset);
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        ahpt_pkg::REG_CENTER_X: cx_q    <= cfg_if.wdata[CW-1:0];
        ahpt_pkg::REG_CENTER_Y: cy_q    <= cfg_if.wdata[CW-1:0];
        ahpt_pkg::REG_CENTER_Z: cz_q    <= cfg_if.wdata[CW-1:0];
        ahpt_pkg::REG_INNER:    inner_q <= cfg_if.wdata[CW-2:0];
        ahpt_pkg::REG_OUTER:    outer_q <= cfg_if.wdata[CW-2:0];
        default: ;
      endcase
    end
  end

  // pipeline advance
  logic out_valid_q;
  logic en;
  assign en          = !out_valid_q || out_if.ready;
  assign in_if.ready = en;

  // stage 1: differences and magnitudes
  logic [CW:0]      mx_q, my_q, mz_q, mu_q, mv_q;
  logic signed [CW-1:0] u1_q, v1_q;
  logic             v1;
  logic signed [CW:0] dx, dy, dz;
  assign dx = (CW+1)'(in_if.data.point_x) - (CW+1)'(cx_q);
  assign dy = (CW+1)'(in_if.data.point_y) - (CW+1)'(cy_q);
  assign dz = (CW+1)'(in_if.data.point_z) - (CW+1)'(cz_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      mx_q <= dx[CW] ? (CW+1)'(-dx) : dx;
      my_q <= dy[CW] ? (CW+1)'(-dy) : dy;
      mz_q <= dz[CW] ? (CW+1)'(-dz) : dz;
      mu_q <= in_if.data.local_u[CW-1] ? (CW+1)'(-(CW+1)'(in_if.data.local_u))
                                       : (CW+1)'(in_if.data.local_u);
      mv_q <= in_if.data.local_v[CW-1] ? (CW+1)'(-(CW+1)'(in_if.data.local_v))
                                       : (CW+1)'(in_if.data.local_v);
      u1_q <= in_if.data.local_u;
      v1_q <= in_if.data.local_v;
    end
  end

  // stage 2: squares
  logic [2*CW+1:0] sx_q, sy_q, sz_q, su_q, sv_q, ri2_q, ro2_q;
  logic signed [CW-1:0] u2_q, v2_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      sx_q  <= mx_q * mx_q;
      sy_q  <= my_q * my_q;
      sz_q  <= mz_q * mz_q;
      su_q  <= mu_q * mu_q;
      sv_q  <= mv_q * mv_q;
      ri2_q <= (2*CW+2)'(inner_q) * (2*CW+2)'(inner_q);
      ro2_q <= (2*CW+2)'(outer_q) * (2*CW+2)'(outer_q);
      u2_q  <= u1_q;
      v2_q  <= v1_q;
    end
  end

  // stage 3: sums and hit compare
  logic [DLW-1:0] d2;
  logic [SQW-1:0] m2_q;
  logic           hit3_q;
  logic signed [CW-1:0] u3_q, v3_q;
  assign d2 = DLW'(sx_q) + DLW'(sy_q) + DLW'(sz_q);
  always_ff @(posedge clk_i) begin
    if (en) begin
      m2_q   <= SQW'(su_q) + SQW'(sv_q);
      hit3_q <= (DLW'(ri2_q) <= d2) && (d2 <= DLW'(ro2_q));
      u3_q   <= u2_q;
      v3_q   <= v2_q;
    end
  end

  // valid bits travel alongside
  localparam int SqDepth  = RW;
  localparam int DivDepth = NW + FRAC_BITS;
  localparam int Total    = 3 + SqDepth + DivDepth;
  logic [Total-1:0] vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Total-2:0], in_if.valid};
    end
  end

  // angle path starts at stage 3, delayed to match
  localparam int AW = ahpt_pkg::AngleWidth;
  localparam int NS = (ANGLE_STAGES < ahpt_pkg::TableLen) ? ANGLE_STAGES : ahpt_pkg::TableLen;
  logic [AW-1:0] ang_c;
  logic          hit_c;
  ahpt_cordic #(.CoordWidth(CW), .AngleStages(ANGLE_STAGES), .SideWidth(1)) u_cordic (
    .clk_i, .en_i(en), .u_i(u3_q), .v_i(v3_q), .side_i(hit3_q),
    .angle_o(ang_c), .side_o(hit_c)
  );
  localparam int ADly = SqDepth + DivDepth - NS;
  logic [AW:0] adl_q [ADly+1];
  assign adl_q[0] = {hit_c, ang_c};
  for (genvar k = 0; k < ADly; k++) begin : g_adl
    always_ff @(posedge clk_i) if (en) adl_q[k+1] <= adl_q[k];
  end

  // radial path
  logic [RW-1:0] root;
  ahpt_isqrt #(.InWidth(SQW), .SideWidth(1)) u_sqrt (
    .clk_i, .en_i(en), .rad_i(m2_q), .side_i(1'b0), .root_o(root), .side_o()
  );
  logic signed [NW-1:0] num, den;
  assign num = NW'(root) - NW'(inner_q);
  assign den = NW'(outer_q) - NW'(inner_q);
  logic signed [CW-1:0] quot;
  logic                 wz;
  ahpt_divider #(.NumWidth(NW), .FracBits(FRAC_BITS), .OutWidth(CW), .SideWidth(1)) u_div (
    .clk_i, .en_i(en), .num_i(num), .den_i(den), .side_i(den == '0),
    .quot_o(quot), .side_o(wz)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= vld_q[Total-1];
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      out_if.data.hit         <= adl_q[ADly][AW];
      out_if.data.angle_turns <= adl_q[ADly][AW-1:0];
      out_if.data.radial_pos  <= wz ? '0 : quot;
      out_if.data.width_zero  <= wz;
    end
  end
  assign out_if.valid = out_valid_q;
endmodule

// File: rtl/ahpt_isqrt.sv
`timescale 1ns / 1ps
// pipelined restoring square root, one result bit per stage
module ahpt_isqrt #(
  parameter int InWidth = 64,
  parameter int SideWidth = 8
) (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic [InWidth-1:0]     rad_i,
  input  logic [SideWidth-1:0]   side_i,
  output logic [InWidth/2-1:0]   root_o,
  output logic [SideWidth-1:0]   side_o
);
  localparam int RW = InWidth / 2;

  logic [InWidth-1:0]   rem_q  [RW+1];
  logic [RW-1:0]        root_q [RW+1];
  logic [InWidth-1:0]   bits_q [RW+1];
  logic [SideWidth-1:0] side_q [RW+1];

  always_comb begin
    rem_q[0]  = '0;
    root_q[0] = '0;
    bits_q[0] = rad_i;
    side_q[0] = side_i;
  end

  for (genvar s = 0; s < RW; s++) begin : g_stage
    logic [InWidth+1:0] rem_sh;
    logic [InWidth+1:0] trial;
    logic               take;
    assign rem_sh = {rem_q[s], bits_q[s][InWidth-1 -: 2]};
    assign trial  = {{(InWidth-RW){1'b0}}, root_q[s], 2'b01};
    assign take   = rem_sh >= trial;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s+1]  <= take ? InWidth'(rem_sh - trial) : InWidth'(rem_sh);
        root_q[s+1] <= {root_q[s][RW-2:0], take};
        bits_q[s+1] <= {bits_q[s][InWidth-3:0], 2'b00};
        side_q[s+1] <= side_q[s];
      end
    end
  end

  assign root_o = root_q[RW];
  assign side_o = side_q[RW];
endmodule

// File: rtl/ahpt_cordic.sv
`timescale 1ns / 1ps
// pipelined cordic vectoring, one micro-rotation per stage
module ahpt_cordic #(
  parameter int CoordWidth = 32,
  parameter int AngleStages = 16,
  parameter int SideWidth = 8
) (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic signed [CoordWidth-1:0] u_i,
  input  logic signed [CoordWidth-1:0] v_i,
  input  logic [SideWidth-1:0]         side_i,
  output logic [ahpt_pkg::AngleWidth-1:0] angle_o,
  output logic [SideWidth-1:0]         side_o
);
  localparam int PreShift = 60 - CoordWidth;
  localparam int XW = 64;
  localparam int AW = ahpt_pkg::AccWidth;
  localparam int NS = (AngleStages < ahpt_pkg::TableLen) ? AngleStages : ahpt_pkg::TableLen;

  logic signed [XW-1:0] x_q [NS+1];
  logic signed [XW-1:0] y_q [NS+1];
  logic [AW-1:0]        acc_q [NS+1];
  logic                 zero_q [NS+1];
  logic [SideWidth-1:0] side_q [NS+1];

  logic signed [XW-1:0] x0, y0;
  always_comb begin
    x0 = -XW'(u_i);
    y0 = -XW'(v_i);
    acc_q[0] = '0;
    if (x0 < 0) begin
      x0 = -x0;
      y0 = -y0;
      acc_q[0] = AW'(1) << (AW - 1);
    end
    x_q[0]    = x0 <<< PreShift;
    y_q[0]    = y0 <<< PreShift;
    zero_q[0] = (u_i == '0) && (v_i == '0);
    side_q[0] = side_i;
  end

  for (genvar i = 0; i < NS; i++) begin : g_rot
    logic signed [XW-1:0] xs, ys;
    assign xs = x_q[i] >>> i;
    assign ys = y_q[i] >>> i;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (y_q[i] > 0) begin
          x_q[i+1]   <= x_q[i] + ys;
          y_q[i+1]   <= y_q[i] - xs;
          acc_q[i+1] <= acc_q[i] + ahpt_pkg::turn_atan(i);
        end else begin
          x_q[i+1]   <= x_q[i] - ys;
          y_q[i+1]   <= y_q[i] + xs;
          acc_q[i+1] <= acc_q[i] - ahpt_pkg::turn_atan(i);
        end
        zero_q[i+1] <= zero_q[i];
        side_q[i+1] <= side_q[i];
      end
    end
  end

  logic [AW-1:0] rnd;
  assign rnd     = acc_q[NS] + AW'(32'h8000);
  assign angle_o = zero_q[NS] ? ahpt_pkg::AngleWidth'(16'h8000) : rnd[AW-1 -: ahpt_pkg::AngleWidth];
  assign side_o  = side_q[NS];
endmodule

// File: rtl/ahpt_divider.sv
`timescale 1ns / 1ps
// pipelined restoring divider with saturation, one quotient bit per stage
module ahpt_divider #(
  parameter int NumWidth = 33,
  parameter int FracBits = 16,
  parameter int OutWidth = 32,
  parameter int SideWidth = 8
) (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic signed [NumWidth-1:0]  num_i,
  input  logic signed [NumWidth-1:0]  den_i,
  input  logic [SideWidth-1:0]        side_i,
  output logic signed [OutWidth-1:0]  quot_o,
  output logic [SideWidth-1:0]        side_o
);
  // quotient bits: integer part then fraction
  localparam int QB = NumWidth + FracBits;
  localparam int DW = NumWidth;

  logic [QB-1:0]        n_q   [QB+1];
  logic [DW-1:0]        d_q   [QB+1];
  logic [DW:0]          r_q   [QB+1];
  logic [QB-1:0]        q_q   [QB+1];
  logic                 neg_q [QB+1];
  logic [SideWidth-1:0] side_q[QB+1];

  always_comb begin
    n_q[0]    = {(num_i[DW-1] ? DW'(-num_i) : DW'(num_i)), {FracBits{1'b0}}};
    d_q[0]    = den_i[DW-1] ? DW'(-den_i) : DW'(den_i);
    r_q[0]    = '0;
    q_q[0]    = '0;
    neg_q[0]  = num_i[DW-1] ^ den_i[DW-1];
    side_q[0] = side_i;
  end

  for (genvar s = 0; s < QB; s++) begin : g_div
    logic [DW+1:0] rs;
    logic          take;
    assign rs   = {r_q[s], n_q[s][QB-1]};
    assign take = rs >= {2'b00, d_q[s]};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[s+1]    <= take ? (DW+1)'(rs - {2'b00, d_q[s]}) : (DW+1)'(rs);
        q_q[s+1]    <= {q_q[s][QB-2:0], take};
        n_q[s+1]    <= {n_q[s][QB-2:0], 1'b0};
        d_q[s+1]    <= d_q[s];
        neg_q[s+1]  <= neg_q[s];
        side_q[s+1] <= side_q[s];
      end
    end
  end

  logic [QB-1:0] lim;
  logic [QB-1:0] qs;
  always_comb begin
    lim = neg_q[QB] ? (QB'(1) << (OutWidth - 1)) : ((QB'(1) << (OutWidth - 1)) - QB'(1));
    qs  = (q_q[QB] > lim) ? lim : q_q[QB];
    quot_o = neg_q[QB] ? OutWidth'(-qs) : OutWidth'(qs);
  end
  assign side_o = side_q[QB];
endmodule

// File: rtl/ahpt_checker.sv
`timescale 1ns / 1ps
module ahpt_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic width_zero_i,
  input logic [31:0] radial_pos_i
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i) else $error("result dropped under stall");
  a_in_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i) else $error("input blocked with empty output");
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |-> !in_ready_i) else $error("input taken during stall");
  a_wz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && width_zero_i |-> radial_pos_i == 32'd0) else $error("radial not zero");
endmodule

bind annulus_hit_and_polar_texcoord ahpt_checker u_ahpt_checker (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .in_valid_i(in_if.valid), .in_ready_i(in_if.ready),
  .out_valid_i(out_if.valid), .out_ready_i(out_if.ready),
  .width_zero_i(out_if.data.width_zero), .radial_pos_i(out_if.data.radial_pos)
);

// File: tb/tb.sv
`timescale 1ns / 1ps
module tb;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic signed [31:0] local_u;
    logic signed [31:0] local_v;
  } ring_in_t;

  typedef struct packed {
    logic               hit;
    logic [15:0]        angle_turns;
    logic signed [31:0] radial_pos;
    logic               width_zero;
  } ring_out_t;

  localparam logic [2:0] RegUnused = 3'd7;
  localparam logic [2:0] RegBeyond = 3'd5;
  localparam int Latency = 3 + (ahpt_pkg::CoordWidth + 1)
                         + (ahpt_pkg::CoordWidth + 3 + ahpt_pkg::FracBits) + 1;
  localparam int MaxGap = 6;

  logic clk_i;
  logic rst_ni;

  ahpt_stream_if #(.payload_t(ring_in_t)) in_if ();
  ahpt_stream_if #(.payload_t(ring_out_t)) out_if ();
  ahpt_cfg_if #(.DataWidth(32)) cfg_if ();

  annulus_hit_and_polar_texcoord dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // ring registers as the block should hold them
  logic [31:0] ring_cx, ring_cy, ring_cz;
  logic [30:0] ring_inner, ring_outer;

  ring_out_t texcoord_q[$];
  int        mismatches;
  int        sink_mode;
  int        stall_cnt;

  logic [31:0] turn_rom [0:15] = '{
    32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C
  };

  function automatic logic [127:0] sq128(input longint a);
    logic [127:0] m;
    m = (a < 0) ? -a : a;
    return m * m;
  endfunction

  function automatic logic [15:0] turn_angle(input longint u, input longint v);
    longint      x, y, xs, ys;
    logic [31:0] acc;
    x = -u;
    y = -v;
    acc = '0;
    if (x == 0 && y == 0) return 16'h8000;
    if (x < 0) begin
      x = -x;
      y = -y;
      acc = 32'h80000000;
    end
    x = x <<< 28;
    y = y <<< 28;
    for (int i = 0; i < ahpt_pkg::AngleStages; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x = x + ys;
        y = y - xs;
        acc = acc + turn_rom[i];
      end else begin
        x = x - ys;
        y = y + xs;
        acc = acc - turn_rom[i];
      end
    end
    acc = acc + 32'h8000;
    return acc[31:16];
  endfunction

  function automatic longint radial_div(input longint num, input longint den);
    logic        neg;
    logic [63:0] n, d, lim, q0, rem, q;
    neg = (num < 0) != (den < 0);
    n = (num < 0) ? -num : num;
    d = (den < 0) ? -den : den;
    lim = neg ? 64'h80000000 : 64'h7FFFFFFF;
    q0 = n / d;
    rem = n % d;
    if (q0 > (lim >> ahpt_pkg::FracBits)) begin
      q = lim;
    end else begin
      q = q0 << ahpt_pkg::FracBits;
      for (int k = ahpt_pkg::FracBits - 1; k >= 0; k--) begin
        rem = rem << 1;
        if (rem >= d) begin
          rem = rem - d;
          q[k] = 1'b1;
        end
      end
      if (q > lim) q = lim;
    end
    return neg ? -longint'(q) : longint'(q);
  endfunction

  function automatic ring_out_t predict_texcoord(input ring_in_t it);
    ring_out_t    r;
    logic [127:0] d2, m2, ri2, ro2;
    logic [63:0]  m, c;
    longint       den;
    d2 = sq128(longint'(it.point_x) - longint'($signed(ring_cx)))
       + sq128(longint'(it.point_y) - longint'($signed(ring_cy)))
       + sq128(longint'(it.point_z) - longint'($signed(ring_cz)));
    ri2 = sq128(longint'(ring_inner));
    ro2 = sq128(longint'(ring_outer));
    r.hit = (ri2 <= d2) && (d2 <= ro2);
    m2 = sq128(it.local_u) + sq128(it.local_v);
    m = '0;
    for (int b = 63; b >= 0; b--) begin
      c = m;
      c[b] = 1'b1;
      if ({64'd0, c} * {64'd0, c} <= m2) m = c;
    end
    r.angle_turns = turn_angle(it.local_u, it.local_v);
    den = longint'(ring_outer) - longint'(ring_inner);
    r.width_zero = (den == 0);
    r.radial_pos = r.width_zero ? '0
                 : 32'(radial_div(longint'(m) - longint'(ring_inner), den));
    return r;
  endfunction

  // receiver stall patterns
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      stall_cnt <= 0;
    end else begin
      stall_cnt <= stall_cnt + 1;
      case (sink_mode)
        0: out_if.ready <= 1'b1;
        1: out_if.ready <= ($urandom_range(0, 1) == 1);
        2: out_if.ready <= (stall_cnt % 7) > 2;
        default: out_if.ready <= ($urandom_range(0, 9) == 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    ring_out_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (texcoord_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_if.data);
      end else begin
        want = texcoord_q.pop_front();
        if (out_if.data.hit !== want.hit || out_if.data.angle_turns !== want.angle_turns ||
            out_if.data.radial_pos !== want.radial_pos ||
            out_if.data.width_zero !== want.width_zero) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp hit %0b ang %h rad %h wz %0b, got hit %0b ang %h rad %h wz %0b",
                     want.hit, want.angle_turns, want.radial_pos, want.width_zero,
                     out_if.data.hit, out_if.data.angle_turns, out_if.data.radial_pos,
                     out_if.data.width_zero);
        end
      end
    end
  end

  task automatic send_item(input ring_in_t it, input int gap);
    in_if.valid <= 1'b1;
    in_if.data <= it;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    texcoord_q.push_back(predict_texcoord(it));
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_uv(input longint px, py, pz, u, v);
    ring_in_t it;
    it.point_x = 32'(px);
    it.point_y = 32'(py);
    it.point_z = 32'(pz);
    it.local_u = 32'(u);
    it.local_v = 32'(v);
    send_item(it, $urandom_range(0, 2));
  endtask

  task automatic drain;
    in_if.valid <= 1'b0;
    while (texcoord_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.wdata <= val;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    case (idx)
      ahpt_pkg::REG_CENTER_X: ring_cx = val;
      ahpt_pkg::REG_CENTER_Y: ring_cy = val;
      ahpt_pkg::REG_CENTER_Z: ring_cz = val;
      ahpt_pkg::REG_INNER:    ring_inner = val[30:0];
      ahpt_pkg::REG_OUTER:    ring_outer = val[30:0];
      default: ;
    endcase
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_ring(input logic [31:0] cx, cy, cz, input logic [31:0] ri, ro);
    drain();
    write_reg(ahpt_pkg::REG_CENTER_X, cx);
    write_reg(ahpt_pkg::REG_CENTER_Y, cy);
    write_reg(ahpt_pkg::REG_CENTER_Z, cz);
    write_reg(ahpt_pkg::REG_INNER, ri);
    write_reg(ahpt_pkg::REG_OUTER, ro);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
      2: return 32'($signed($urandom_range(0, 32'h00100000)) - 32'sh00080000);
      3: return 32'($urandom_range(0, 3)) - 32'd1;
      default: return 32'($signed($urandom_range(0, 32'h08000000)) - 32'sh04000000);
    endcase
  endfunction

  task automatic test_defaults;
    // angle on the axes, zero vector, field extremes, hit boundaries
    send_uv(0, 0, 0, 0, 0);
    send_uv(32'h10000, 0, 0, 32'h10000, 0);
    send_uv(32'h20000, 0, 0, 0, 32'h10000);
    send_uv(32'h20001, 0, 0, -32'sh10000, 0);
    send_uv(32'hFFFF, 0, 0, 0, -32'sh10000);
    send_uv(0, 32'h18000, 0, -32'sh10000, -1);
    send_uv(0, 0, 32'h18000, -32'sh10000, 1);
    send_uv(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
    send_uv(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
    send_uv(32'h80000000, 32'h7FFFFFFF, 0, 32'h80000000, 32'h7FFFFFFF);
    send_uv(-1, -1, -1, -1, -1);
    send_uv(32'h0C000, 32'h0C000, 0, 1, 0);
    drain();
  endtask

  task automatic test_ring_extremes;
    set_ring(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF);
    send_uv(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 0);
    send_uv(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 0, 0);
    // zero width still hits only on the radius
    set_ring(0, 0, 0, 32'h10000, 32'h10000);
    send_uv(32'h10000, 0, 0, 32'h8000, 32'h8000);
    send_uv(32'h10001, 0, 0, 32'h20000, 0);
    // inverted ring and radial saturation both ways
    set_ring(0, 0, 0, 32'h20000, 32'h10000);
    send_uv(32'h18000, 0, 0, 32'h7FFFFFFF, 32'h7FFFFFFF);
    send_uv(32'h18000, 0, 0, 0, 0);
    set_ring(0, 0, 0, 0, 1);
    send_uv(0, 0, 0, 32'h7FFFFFFF, 32'h80000000);
    send_uv(0, 0, 0, 1, 0);
    set_ring(0, 0, 0, 32'h7FFFFFFF, 0);
    send_uv(0, 0, 0, 0, 0);
    send_uv(0, 0, 0, 32'h80000000, 32'h80000000);
    // an unused index leaves the ring alone
    drain();
    write_reg(RegUnused, 32'h12345678);
    write_reg(RegBeyond, 32'hFFFFFFFF);
    send_uv(0, 0, 0, 32'h10000, 32'h10000);
    drain();
  endtask

  task automatic test_random_phases;
    logic [31:0] cx, cy, cz, ri, ro;
    longint      reach, burst;
    ring_in_t    it;
    for (int ph = 0; ph < 8; ph++) begin
      cx = rand_coord();
      cy = rand_coord();
      cz = rand_coord();
      case (ph % 4)
        0: begin ri = $urandom_range(0, 32'h80000); ro = ri + $urandom_range(1, 32'h80000); end
        1: begin ri = $urandom(); ro = $urandom(); end
        2: begin ri = $urandom_range(0, 32'h40000); ro = ri; end
        default: begin ri = $urandom_range(1, 32'h40000); ro = ri - $urandom_range(0, 1) * 2; end
      endcase
      set_ring(cx, cy, cz, ri, ro);
      sink_mode = ph % 4;
      reach = longint'(ro[30:0]) + 1;
      burst = 0;
      for (int n = 0; n < 128; n++) begin
        if ($urandom_range(0, 3) != 0) begin
          // near the ring so that hits are common
          it.point_x = 32'(longint'($signed(cx))
                           + longint'($urandom_range(0, 32'(2 * reach))) - reach);
          it.point_y = 32'(longint'($signed(cy))
                           + longint'($urandom_range(0, 32'(2 * reach))) - reach);
          it.point_z = 32'(longint'($signed(cz)) + longint'($urandom_range(0, 3)) - 1);
        end else begin
          it.point_x = rand_coord();
          it.point_y = rand_coord();
          it.point_z = rand_coord();
        end
        it.local_u = rand_coord();
        it.local_v = rand_coord();
        if (burst > 0) begin
          burst--;
          send_item(it, 0);
        end else begin
          burst = $urandom_range(0, 12);
          send_item(it, $urandom_range(0, MaxGap));
        end
      end
      if (ph == 3) drain();
    end
    drain();
  endtask

  initial begin
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.data = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = ahpt_pkg::REG_CENTER_X;
    cfg_if.wdata = '0;
    sink_mode = 0;
    mismatches = 0;
    ring_cx = '0;
    ring_cy = '0;
    ring_cz = '0;
    ring_inner = ahpt_pkg::InnerReset[30:0];
    ring_outer = ahpt_pkg::OuterReset[30:0];
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_defaults();
    sink_mode = 1;
    test_ring_extremes();
    test_random_phases();
    repeat (Latency + 20) @(posedge clk_i);
    if (mismatches == 0 && texcoord_q.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  initial begin
    #8ms;
    $display("tb NOT OK");
    $finish;
  end

endmodule
